[sv/dms_pkg.sv]
// Package with the shared types and constants of the diagram Metropolis step block.
`default_nettype none
package dms_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SHIFT_S    = 2 * FRAC_BITS - 16;
    localparam int DRAW_W     = 16;
    localparam int WGT_W      = 24;
    localparam int WSUM_W     = 26;
    localparam int CUM_W      = 28;
    localparam int CNT_W      = 9;
    localparam int HGT_W      = 8;
    localparam int PROD_W     = WGT_W + WSUM_W;
    localparam int DP_W       = PROD_W + DRAW_W;
    localparam int TPROD_W    = DRAW_W + WSUM_W;
    localparam int SUM_SPLIT  = 13;
    localparam int PROD_SPLIT = 25;
    localparam int LVL_W      = HGT_W + 1 + WSUM_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [HGT_W-1:0] STACK_TOP = 8'd255;

    localparam logic [2:0] REG_FWD_PROB  = 3'd0;
    localparam logic [2:0] REG_FWD_RATIO = 3'd1;
    localparam logic [2:0] REG_W_CREATE  = 3'd2;
    localparam logic [2:0] REG_W_LINE    = 3'd3;
    localparam logic [2:0] REG_W_VERTEX  = 3'd4;
    localparam logic [2:0] REG_W_JOIN    = 3'd5;
    localparam logic [2:0] REG_COUPLING  = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LVL, ST_TOP, ST_EVAL, ST_LVL2, ST_TOP2,
        ST_MUL, ST_COPY, ST_MOVE, ST_DONE
    } step_state_t;

    typedef enum logic [2:0] {
        AP_IDLE, AP_P0, AP_P1, AP_FWD, AP_B0, AP_B1, AP_BCMP
    } acc_phase_t;

    typedef enum logic [1:0] {
        MV_CREATE, MV_LINE, MV_VERTEX, MV_JOIN
    } move_t;

    typedef struct packed {
        logic              start;
        logic              forward;
        logic [WGT_W-1:0]  ratio;
        logic [WSUM_W-1:0] sum;
        logic [DRAW_W-1:0] draw;
    } acc_req_t;

    typedef struct packed {
        logic done;
        logic accept;
    } acc_resp_t;

endpackage
`default_nettype wire

[sv/dms_accept.sv]
// Multi-cycle Metropolis acceptance test by partial-product multiply and compare.
`default_nettype none
module dms_accept
    import dms_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire acc_req_t  req,
    output acc_resp_t      resp
);

    acc_phase_t        phase_reg;
    logic              fwd_reg;
    logic [WGT_W-1:0]  ratio_reg;
    logic [WSUM_W-1:0] sum_reg;
    logic [DRAW_W-1:0] draw_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DP_W-1:0]   dp_reg;
    acc_resp_t         resp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= AP_IDLE;
            resp_reg  <= '0;
        end else begin
            unique case (phase_reg)
                AP_IDLE: begin
                    resp_reg <= '0;
                    if (req.start) begin
                        phase_reg <= AP_P0;
                    end
                end
                AP_P0: phase_reg <= AP_P1;
                AP_P1: phase_reg <= fwd_reg ? AP_FWD : AP_B0;
                AP_FWD: begin
                    resp_reg  <= '{done: 1'b1,
                                   accept: (DP_W'(draw_reg) << SHIFT_S) < DP_W'(prod_reg)};
                    phase_reg <= AP_IDLE;
                end
                AP_B0: phase_reg <= AP_B1;
                AP_B1: phase_reg <= AP_BCMP;
                AP_BCMP: begin
                    resp_reg  <= '{done: 1'b1,
                                   accept: (prod_reg == '0) ||
                                           (dp_reg[DP_W-1:SHIFT_S+32] == '0)};
                    phase_reg <= AP_IDLE;
                end
                default: phase_reg <= AP_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == AP_IDLE && req.start) begin
            fwd_reg   <= req.forward;
            ratio_reg <= req.ratio;
            sum_reg   <= req.sum;
            draw_reg  <= req.draw;
        end
        if (phase_reg == AP_P0) begin
            prod_reg <= PROD_W'(ratio_reg) * PROD_W'(sum_reg[SUM_SPLIT-1:0]);
        end
        if (phase_reg == AP_P1) begin
            prod_reg <= prod_reg + ((PROD_W'(ratio_reg) *
                        PROD_W'(sum_reg[WSUM_W-1:SUM_SPLIT])) << SUM_SPLIT);
        end
        if (phase_reg == AP_B0) begin
            dp_reg <= DP_W'(draw_reg) * DP_W'(prod_reg[PROD_SPLIT-1:0]);
        end
        if (phase_reg == AP_B1) begin
            dp_reg <= dp_reg + ((DP_W'(draw_reg) *
                      DP_W'(prod_reg[PROD_W-1:PROD_SPLIT])) << PROD_SPLIT);
        end
    end

    assign resp = resp_reg;

endmodule
`default_nettype wire

[sv/diagram_metropolis_step.sv]
// Top level of the diagram Metropolis step block: sequencer, state memories, result register.
// One item performs one Metropolis step of the expansion-order walk. An accepted forward
// step copies the current level into the next one entry per cycle through the line-count
// memory, so its duration grows with h, the stack height of the current level. A result still
// waiting on the m_ channel holds the following item until it is taken. Level 0 needs no
// clearing pass: its entries are held constant in logic. The block takes one item at a
// time; s_ready is high while it is idle, even when a finished result is still waiting.
`default_nettype none
module diagram_metropolis_step
    import dms_pkg::*;
#(
    parameter int MAX_ORDER = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [DRAW_W-1:0] s_draw_direction,
    input  wire logic [DRAW_W-1:0] s_draw_accept,
    input  wire logic [DRAW_W-1:0] s_draw_move,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_accepted,
    output logic [7:0]             m_current_order,
    output logic                   m_sign_negative,
    output logic [HGT_W-1:0]       m_stack_height,
    output logic [CNT_W-1:0]       m_top_count,
    output logic                   m_overflow,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [WGT_W-1:0]  cfg_data
);

    localparam int OW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int LA_W = OW + HGT_W;
    localparam logic [OW-1:0] ORDER_TOP = OW'(MAX_ORDER - 1);

    logic [DRAW_W-1:0] fwd_prob_reg;
    logic [WGT_W-1:0]  fwd_ratio_reg, w_create_reg, w_line_reg, w_vertex_reg, w_join_reg;
    logic              coupling_reg;

    step_state_t state_reg, state_next;
    logic [OW-1:0]     order_reg;
    logic [DRAW_W-1:0] d_acc_reg, d_move_reg;
    logic              forward_reg, ovf_reg;
    logic [HGT_W-1:0]  cur_h_reg, prev_h_reg;
    logic              cur_sign_reg, prev_sign_reg;
    logic [CNT_W-1:0]  cur_top_reg, prev_top_reg, below_reg;
    logic [WSUM_W-1:0] sum_reg;
    logic [CUM_W-1:0]  cum1_reg, cum2_reg;
    logic [TPROD_W-1:0] t_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              res_acc_reg, res_sign_reg, res_ovf_reg;
    logic [HGT_W-1:0]  res_h_reg;
    logic [CNT_W-1:0]  res_top_reg;

    logic              m_valid_reg, m_acc_reg, m_sign_reg, m_ovf_reg;
    logic [7:0]        m_order_reg;
    logic [HGT_W-1:0]  m_h_reg;
    logic [CNT_W-1:0]  m_top_reg;

    logic [LVL_W-1:0] lvl_mem [MAX_ORDER];
    logic [CNT_W-1:0] line_mem [MAX_ORDER * 256];
    logic [LVL_W-1:0] lvl_rdata_reg;
    logic             lvl_zero_reg;
    logic [CNT_W-1:0] line_rdata_reg;
    logic             line_zero_reg;

    logic             lvl_re, lvl_we, line_re, line_we;
    logic [OW-1:0]    lvl_raddr, lvl_waddr;
    logic [LVL_W-1:0] lvl_wdata;
    logic [LA_W-1:0]  line_raddr, line_waddr;
    logic [CNT_W-1:0] line_wdata;

    logic [HGT_W-1:0]  lvl_h;
    logic              lvl_sign;
    logic [WSUM_W-1:0] lvl_wsum;
    logic [CNT_W-1:0]  line_q;

    logic              s_fire, out_free;
    logic [OW-1:0]     order_up, order_dn;
    logic [WSUM_W-1:0] w2, w3, sum_next;
    logic [CUM_W-1:0]  cum0, cum1_next, cum2_next;
    move_t             move;
    logic [CNT_W:0]    line_inc, join_sum;
    logic [CNT_W-1:0]  line_sat, join_sat;
    logic [HGT_W-1:0]  mv_h;
    logic              mv_sign;
    logic [CNT_W-1:0]  mv_top;
    logic [OW+7:0]     order_ext;
    acc_req_t          acc_req;
    acc_resp_t         acc_resp;

    dms_accept u_accept (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (acc_req),
        .resp    (acc_resp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_prob_reg  <= 16'd32768;
            fwd_ratio_reg <= 24'd65536;
            w_create_reg  <= 24'd65536;
            w_line_reg    <= 24'd65536;
            w_vertex_reg  <= 24'd65536;
            w_join_reg    <= 24'd65536;
            coupling_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FWD_PROB:  fwd_prob_reg  <= cfg_data[DRAW_W-1:0];
                REG_FWD_RATIO: fwd_ratio_reg <= cfg_data;
                REG_W_CREATE:  w_create_reg  <= cfg_data;
                REG_W_LINE:    w_line_reg    <= cfg_data;
                REG_W_VERTEX:  w_vertex_reg  <= cfg_data;
                REG_W_JOIN:    w_join_reg    <= cfg_data;
                REG_COUPLING:  coupling_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign order_up = order_reg + 1'b1;
    assign order_dn = order_reg - 1'b1;

    assign lvl_h    = lvl_zero_reg ? '0 : lvl_rdata_reg[LVL_W-1:WSUM_W+1];
    assign lvl_sign = lvl_zero_reg ? 1'b0 : lvl_rdata_reg[WSUM_W];
    assign lvl_wsum = lvl_rdata_reg[WSUM_W-1:0];
    assign line_q   = line_zero_reg ? CNT_W'(1) : line_rdata_reg;

    assign w2        = (cur_top_reg > CNT_W'(1)) ? WSUM_W'(w_vertex_reg) : '0;
    assign w3        = (cur_h_reg != '0) ? WSUM_W'(w_join_reg) : '0;
    assign cum0      = CUM_W'(w_create_reg);
    assign cum1_next = cum0 + CUM_W'(w_line_reg);
    assign cum2_next = cum1_next + CUM_W'(w2);
    assign sum_next  = WSUM_W'(cum2_next + CUM_W'(w3));

    always_comb begin
        priority if ((CUM_W+16)'(t_reg) < {cum0, 16'd0}) begin
            move = MV_CREATE;
        end else if ((CUM_W+16)'(t_reg) < {cum1_reg, 16'd0}) begin
            move = MV_LINE;
        end else if ((CUM_W+16)'(t_reg) < {cum2_reg, 16'd0}) begin
            move = MV_VERTEX;
        end else begin
            move = MV_JOIN;
        end
    end

    assign line_inc = {1'b0, cur_top_reg} + 1'b1;
    assign line_sat = line_inc[CNT_W] ? COUNT_MAX : line_inc[CNT_W-1:0];
    assign join_sum = {1'b0, below_reg} + {1'b0, cur_top_reg} + 1'b1;
    assign join_sat = join_sum[CNT_W] ? COUNT_MAX : join_sum[CNT_W-1:0];

    always_comb begin
        mv_h    = cur_h_reg;
        mv_sign = cur_sign_reg;
        mv_top  = cur_top_reg;
        unique case (move)
            MV_CREATE: begin
                if (cur_h_reg != STACK_TOP) begin
                    mv_h   = cur_h_reg + 1'b1;
                    mv_top = CNT_W'(1);
                end
            end
            MV_LINE:   mv_top = line_sat;
            MV_VERTEX: begin
                mv_top  = cur_top_reg - 1'b1;
                mv_sign = cur_sign_reg ^ coupling_reg;
            end
            MV_JOIN: begin
                mv_h   = cur_h_reg - 1'b1;
                mv_top = join_sat;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        lvl_re     = 1'b0;
        lvl_raddr  = order_reg;
        lvl_we     = 1'b0;
        lvl_waddr  = order_reg;
        lvl_wdata  = {cur_h_reg, cur_sign_reg, sum_next};
        line_re    = 1'b0;
        line_raddr = {order_reg, lvl_h};
        line_we    = 1'b0;
        line_waddr = {order_up, cnt_reg[HGT_W-1:0] - 1'b1};
        line_wdata = line_q;
        acc_req.start   = 1'b0;
        acc_req.forward = 1'b1;
        acc_req.ratio   = fwd_ratio_reg;
        acc_req.sum     = sum_next;
        acc_req.draw    = d_acc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    lvl_re     = 1'b1;
                    state_next = ST_LVL;
                end
            end
            ST_LVL: begin
                line_re    = 1'b1;
                state_next = ST_TOP;
            end
            ST_TOP: begin
                if (forward_reg) begin
                    state_next = ST_EVAL;
                end else if (order_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    lvl_re     = 1'b1;
                    lvl_raddr  = order_dn;
                    state_next = ST_LVL2;
                end
            end
            ST_EVAL: begin
                lvl_we        = 1'b1;
                acc_req.start = 1'b1;
                state_next    = ST_MUL;
            end
            ST_LVL2: begin
                line_re         = 1'b1;
                line_raddr      = {order_dn, lvl_h};
                acc_req.start   = 1'b1;
                acc_req.forward = 1'b0;
                acc_req.sum     = lvl_wsum;
                state_next      = ST_TOP2;
            end
            ST_TOP2: state_next = ST_MUL;
            ST_MUL: begin
                if (acc_resp.done) begin
                    state_next = (forward_reg && acc_resp.accept) ? ST_COPY : ST_DONE;
                end
            end
            ST_COPY: begin
                if (cnt_reg <= {1'b0, cur_h_reg}) begin
                    line_re    = 1'b1;
                    line_raddr = {order_reg, cnt_reg[HGT_W-1:0]};
                end
                if (cnt_reg != '0) begin
                    line_we = 1'b1;
                end
                if (cnt_reg == {1'b0, cur_h_reg} + 1'b1) begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: begin
                lvl_we    = 1'b1;
                lvl_waddr = order_up;
                lvl_wdata = {mv_h, mv_sign, WSUM_W'(0)};
                unique case (move)
                    MV_CREATE: begin
                        line_we    = (cur_h_reg != STACK_TOP);
                        line_waddr = {order_up, cur_h_reg + 1'b1};
                        line_wdata = CNT_W'(1);
                    end
                    MV_LINE, MV_VERTEX: begin
                        line_we    = 1'b1;
                        line_waddr = {order_up, cur_h_reg};
                        line_wdata = mv_top;
                    end
                    MV_JOIN: begin
                        line_we    = 1'b1;
                        line_waddr = {order_up, cur_h_reg - 1'b1};
                        line_wdata = join_sat;
                    end
                    default: ;
                endcase
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (lvl_re) begin
            lvl_rdata_reg <= lvl_mem[lvl_raddr];
            lvl_zero_reg  <= (lvl_raddr == '0);
        end
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (line_re) begin
            line_rdata_reg <= line_mem[line_raddr];
            line_zero_reg  <= (line_raddr[LA_W-1:HGT_W] == '0);
        end
        if (line_we) begin
            line_mem[line_waddr] <= line_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= '0;
        end else if (state_reg == ST_MOVE) begin
            order_reg <= order_up;
        end else if (state_reg == ST_MUL && acc_resp.done && !forward_reg &&
                     acc_resp.accept) begin
            order_reg <= order_dn;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    d_acc_reg   <= s_draw_accept;
                    d_move_reg  <= s_draw_move;
                    ovf_reg     <= (order_reg >= ORDER_TOP);
                    forward_reg <= (order_reg < ORDER_TOP) &&
                                   (s_draw_direction <= fwd_prob_reg);
                end
            end
            ST_LVL: begin
                cur_h_reg    <= lvl_h;
                cur_sign_reg <= lvl_sign;
            end
            ST_TOP: begin
                cur_top_reg <= line_q;
                if (!forward_reg && order_reg == '0) begin
                    res_acc_reg  <= 1'b1;
                    res_sign_reg <= 1'b0;
                    res_h_reg    <= '0;
                    res_top_reg  <= CNT_W'(1);
                    res_ovf_reg  <= ovf_reg;
                end
            end
            ST_EVAL: begin
                sum_reg  <= sum_next;
                cum1_reg <= cum1_next;
                cum2_reg <= cum2_next;
            end
            ST_LVL2: begin
                prev_h_reg    <= lvl_h;
                prev_sign_reg <= lvl_sign;
            end
            ST_TOP2: prev_top_reg <= line_q;
            ST_MUL: begin
                t_reg   <= TPROD_W'(d_move_reg) * TPROD_W'(sum_reg);
                cnt_reg <= '0;
                if (acc_resp.done) begin
                    res_ovf_reg <= ovf_reg;
                    if (!forward_reg && acc_resp.accept) begin
                        res_acc_reg  <= 1'b1;
                        res_sign_reg <= prev_sign_reg;
                        res_h_reg    <= prev_h_reg;
                        res_top_reg  <= prev_top_reg;
                    end else begin
                        res_acc_reg  <= 1'b0;
                        res_sign_reg <= cur_sign_reg;
                        res_h_reg    <= cur_h_reg;
                        res_top_reg  <= cur_top_reg;
                    end
                end
            end
            ST_COPY: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {1'b0, cur_h_reg} && cur_h_reg != '0) begin
                    below_reg <= line_q;
                end
            end
            ST_MOVE: begin
                res_acc_reg  <= 1'b1;
                res_sign_reg <= mv_sign;
                res_h_reg    <= mv_h;
                res_top_reg  <= mv_top;
            end
            default: ;
        endcase
    end

    assign order_ext = {8'd0, order_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_acc_reg   <= res_acc_reg;
            m_order_reg <= order_ext[7:0];
            m_sign_reg  <= res_sign_reg;
            m_h_reg     <= res_h_reg;
            m_top_reg   <= res_top_reg;
            m_ovf_reg   <= res_ovf_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = m_acc_reg;
    assign m_current_order = m_order_reg;
    assign m_sign_negative = m_sign_reg;
    assign m_stack_height  = m_h_reg;
    assign m_top_count     = m_top_reg;
    assign m_overflow      = m_ovf_reg;

`ifndef SYNTHESIS
    a_order_range: assert property (@(posedge aclk) disable iff (!aresetn)
        order_reg <= ORDER_TOP)
        else $error("order went past the top level");
    a_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_resp.done |-> state_reg == ST_MUL)
        else $error("acceptance result arrived outside the wait state");
    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COPY |-> cnt_reg <= {1'b0, cur_h_reg} + 1'b1)
        else $error("level copy ran past the stack top");
`endif

endmodule
`default_nettype wire
